// ===== sv/sro_pkg.sv =====
package sro_pkg;

    localparam int REG_WIDTH = 8;
    localparam int BIT_W     = $clog2(REG_WIDTH);
    localparam int BYTE_W    = 8;
    localparam int DELAY_W   = 24;

    localparam logic [DELAY_W-1:0] STEP_DELAY_RESET = DELAY_W'(800000);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RAMP  = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] value;
        logic [2:0]        bit_index;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] latched_byte;
        logic              last;
    } t_out_word;

    // one write request from the sequencer to the serializer
    typedef struct packed {
        logic                 valid;
        logic [REG_WIDTH-1:0] data;
        logic                 last;
    } t_wr_req;

endpackage

// ===== sv/shift_register_output_ramp.sv =====
// an idle block accepts the input word, then the controller issues it, the serializer loads it,
// shifts it out msb first and strobes the latched word onto the output
// write, set and clear: each word waits for the bit-serial shifter to finish the previous one
// ramp: up to 8 words with the step delay between them, input stalled throughout
// reset: synchronous active low, shadow byte cleared, step_delay set to 800000
module shift_register_output_ramp
    import sro_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_word           i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_word          o_data,
    input  logic               i_cfg_we,
    input  logic [DELAY_W-1:0] i_cfg_data
);

    t_wr_req w_req;
    logic    w_ready;

    sro_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_req      (w_req),
        .i_ready    (w_ready)
    );

    sro_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_ready (w_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== sv/sro_shift.sv =====
module sro_shift
    import sro_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_wr_req   i_req,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SHIFT  = 2'd1;
    localparam logic [1:0] S_STROBE = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [REG_WIDTH-1:0] r_sr, n_sr;
    logic [REG_WIDTH-1:0] r_cap, n_cap;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic                 r_last, n_last;
    logic                 r_ovalid, n_ovalid;
    t_out_word            r_out, n_out;
    logic                 w_out_free;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_data     = r_out;

    always_comb begin
        n_state  = r_state;
        n_sr     = r_sr;
        n_cap    = r_cap;
        n_bit    = r_bit;
        n_last   = r_last;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_sr    = i_req.data;
                    n_last  = i_req.last;
                    n_bit   = '0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // msb first onto the serial line, clocked into the far register
                n_cap = {r_cap[REG_WIDTH-2:0], r_sr[REG_WIDTH-1]};
                n_sr  = {r_sr[REG_WIDTH-2:0], 1'b0};
                if (r_bit == BIT_W'(REG_WIDTH - 1)) begin
                    n_bit   = '0;
                    n_state = S_STROBE;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            S_STROBE: begin
                // strobe latches the shifted word; holds while the output is full
                if (w_out_free) begin
                    n_out.latched_byte = BYTE_W'(r_cap);
                    n_out.last         = r_last;
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bit    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bit    <= n_bit;
            r_ovalid <= n_ovalid;
        end
        r_sr   <= n_sr;
        r_cap  <= n_cap;
        r_last <= n_last;
        r_out  <= n_out;
    end

    a_req_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> r_state == S_IDLE)
        else $error("write request while serializer busy");

    a_bit_zero_outside_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_SHIFT |-> r_bit == '0)
        else $error("bit counter not cleared");

    a_strobe_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STROBE && w_out_free) |=> (r_ovalid && r_state == S_IDLE))
        else $error("latched word not presented");

endmodule

// ===== sv/sro_ctrl.sv =====
module sro_ctrl
    import sro_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_word           i_data,
    input  logic               i_cfg_we,
    input  logic [DELAY_W-1:0] i_cfg_data,
    output t_wr_req            o_req,
    input  logic               i_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DELAY = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [REG_WIDTH-1:0] r_shown, n_shown;
    logic [REG_WIDTH-1:0] r_byte, n_byte;
    logic                 r_last, n_last;
    logic [REG_WIDTH-1:0] r_tgt, n_tgt;
    logic                 r_down, n_down;
    logic [BIT_W-1:0]     r_cnt, n_cnt;
    logic [DELAY_W-1:0]   r_dly, n_dly;
    logic [DELAY_W-1:0]   r_step_delay;

    logic                 w_idle;
    logic                 w_down;
    logic [REG_WIDTH-1:0] w_tgt;
    logic [BIT_W-1:0]     w_cnt;
    logic [REG_WIDTH-1:0] w_nv;
    logic                 w_last;
    logic [REG_WIDTH-1:0] w_mask;

    assign w_idle  = (r_state == ST_IDLE);
    assign o_stall = !w_idle;

    // next ramp step: first step straight from the input, later ones from the held target
    always_comb begin
        w_tgt  = w_idle ? REG_WIDTH'(i_data.value) : r_tgt;
        w_down = w_idle ? (w_tgt < r_shown) : r_down;
        w_cnt  = w_idle ? '0 : r_cnt + 1'b1;
        w_nv   = w_down ? (r_shown >> 1) : {r_shown[REG_WIDTH-2:0], 1'b1};
        w_last = (w_cnt == BIT_W'(REG_WIDTH - 1))
              || (w_down ? !(w_tgt < w_nv) : !(w_tgt > w_nv));
        // index past the register width selects no bit
        w_mask = REG_WIDTH'(1) << i_data.bit_index;
    end

    always_comb begin
        n_state = r_state;
        n_shown = r_shown;
        n_byte  = r_byte;
        n_last  = r_last;
        n_tgt   = r_tgt;
        n_down  = r_down;
        n_cnt   = r_cnt;
        n_dly   = r_dly;
        o_req   = '{valid: 1'b0, data: r_byte, last: r_last};
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_last  = 1'b1;
                    n_state = ST_ISSUE;
                    case (i_data.opcode)
                        OP_WRITE: n_byte = REG_WIDTH'(i_data.value);
                        OP_SET:   n_byte = r_shown | w_mask;
                        OP_CLEAR: n_byte = r_shown & ~w_mask;
                        OP_RAMP: begin
                            n_byte = w_nv;
                            n_last = w_last;
                            n_tgt  = w_tgt;
                            n_down = w_down;
                            n_cnt  = w_cnt;
                            // already at target: nothing shown
                            if (w_tgt == r_shown) begin
                                n_state = ST_IDLE;
                            end
                        end
                        default: n_byte = r_byte;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (i_ready) begin
                    o_req.valid = 1'b1;
                    n_shown     = r_byte;
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_dly   = r_step_delay;
                        n_state = ST_DELAY;
                    end
                end
            end
            ST_DELAY: begin
                if (r_dly <= DELAY_W'(1)) begin
                    n_byte  = w_nv;
                    n_last  = w_last;
                    n_cnt   = w_cnt;
                    n_state = ST_ISSUE;
                end else begin
                    n_dly = r_dly - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_shown      <= '0;
            r_step_delay <= STEP_DELAY_RESET;
        end else begin
            r_state <= n_state;
            r_shown <= n_shown;
            if (i_cfg_we) begin
                r_step_delay <= i_cfg_data;
            end
        end
        r_byte <= n_byte;
        r_last <= n_last;
        r_tgt  <= n_tgt;
        r_down <= n_down;
        r_cnt  <= n_cnt;
        r_dly  <= n_dly;
    end

    a_nonlast_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req.valid && !o_req.last) |=> r_state == ST_DELAY)
        else $error("ramp step not followed by delay");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req.valid && o_req.last) |=> (r_state == ST_IDLE && r_shown == $past(r_byte)))
        else $error("final word did not update shadow and finish");

endmodule

// ===== dv/sro_latch_checker.sv =====
module sro_latch_checker
    import sro_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_word           i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_word          i_out_word,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [REG_WIDTH-1:0] shadow = '0;
    t_out_word            latch_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // every latched byte that one command word causes, in order
    function automatic void predict_latches(input t_in_word w);
        logic [REG_WIDTH-1:0] mask;
        logic [REG_WIDTH-1:0] seq[$];
        t_out_word            exp_w;
        mask = REG_WIDTH'(1) << w.bit_index;
        case (w.opcode)
            OP_WRITE: begin
                shadow = REG_WIDTH'(w.value);
                seq.push_back(shadow);
            end
            OP_RAMP: begin
                if (w.value < shadow) begin
                    while (w.value < shadow && seq.size() < REG_WIDTH) begin
                        shadow = shadow >> 1;
                        seq.push_back(shadow);
                    end
                end else begin
                    // bar graph fill: shift left, feed a one in at the bottom
                    while (w.value > shadow && seq.size() < REG_WIDTH) begin
                        shadow = {shadow[REG_WIDTH-2:0], 1'b1};
                        seq.push_back(shadow);
                    end
                end
            end
            OP_SET: begin
                shadow = shadow | mask;
                seq.push_back(shadow);
            end
            OP_CLEAR: begin
                shadow = shadow & ~mask;
                seq.push_back(shadow);
            end
            default: ;
        endcase
        for (int i = 0; i < seq.size(); i++) begin
            exp_w.latched_byte = BYTE_W'(seq[i]);
            exp_w.last         = (i == seq.size() - 1);
            latch_q.push_back(exp_w);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            shadow = '0;
            latch_q.delete();
        end else begin
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (latch_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected latched word: byte %02h last %0b",
                                 i_out_word.latched_byte, i_out_word.last);
                    o_errors++;
                end else begin
                    exp_w = latch_q.pop_front();
                    if (i_out_word.latched_byte !== exp_w.latched_byte ||
                        i_out_word.last !== exp_w.last) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %02h/%0b, got %02h/%0b",
                                     exp_w.latched_byte, exp_w.last,
                                     i_out_word.latched_byte, i_out_word.last);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                predict_latches(i_in_word);
        end
        o_pending = latch_q.size();
    end

endmodule

// ===== dv/shift_register_output_ramp_tb.sv =====
module shift_register_output_ramp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sro_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE      = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_in_word           i_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_out_word          o_data;
    logic               i_cfg_we = 1'b0;
    logic [DELAY_W-1:0] i_cfg_data = '0;

    int                 mismatches;
    int                 pending;
    int                 quiet_cycles = 0;
    bit                 tx_idle_en = 1'b1;
    bit                 rx_idle_en = 1'b1;
    bit                 ramps_on = 1'b1;
    logic [DELAY_W-1:0] cur_delay = STEP_DELAY_RESET;
    int unsigned        rx_run = 0;
    logic               rx_hold = 1'b0;

    shift_register_output_ramp u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    sro_latch_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_word   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_word  (o_data),
        .o_errors    (mismatches),
        .o_pending   (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    always @(negedge i_clk) begin
        if (rx_run == 0) begin
            rx_hold = rx_idle_en && ($urandom_range(0, 2) == 0);
            rx_run  = rx_hold ? pick_gap() : $urandom_range(1, 30);
        end
        rx_run--;
        i_stall <= rx_hold;
    end

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_in_word mk_word(input logic [1:0] op, input logic [BYTE_W-1:0] val,
                                         input logic [2:0] idx);
        t_in_word w;
        w.opcode    = op;
        w.value     = val;
        w.bit_index = idx;
        return w;
    endfunction

    function automatic t_in_word random_word(input bit allow_ramp);
        t_in_word    w;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (allow_ramp && r < 35)
            w.opcode = OP_RAMP;
        else if (r < 60)
            w.opcode = OP_WRITE;
        else if (r < 80)
            w.opcode = OP_SET;
        else
            w.opcode = OP_CLEAR;
        r = $urandom_range(0, 9);
        if (r < 2)
            w.value = '0;
        else if (r < 4)
            w.value = '1;
        else
            w.value = BYTE_W'($urandom());
        w.bit_index = 3'($urandom_range(0, 7));
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 55) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // stop sending and wait until every latched word has come back
    task automatic idle_until_empty(input int unsigned extra);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_step_delay(input logic [DELAY_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_delay = d;
    endtask

    task automatic run_phase(input logic [DELAY_W-1:0] d, input int count,
                             input bit allow_ramp, input bit idle_en);
        // a ramp to the current value latches nothing and does not keep the block busy
        idle_until_empty(SETTLE + (ramps_on ? cur_delay : 0));
        write_step_delay(d);
        ramps_on   = allow_ramp;
        tx_idle_en = idle_en;
        rx_idle_en = idle_en;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                idle_until_empty(0);
            send_word(random_word(allow_ramp));
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_step_delay(DELAY_W'(1));

        send_word(mk_word(OP_RAMP,  8'h00, 3'd0));
        send_word(mk_word(OP_WRITE, 8'hFF, 3'd7));
        send_word(mk_word(OP_WRITE, 8'h00, 3'd0));
        send_word(mk_word(OP_SET,   8'h00, 3'd0));
        send_word(mk_word(OP_SET,   8'hFF, 3'd7));
        send_word(mk_word(OP_SET,   8'h00, 3'd7));
        send_word(mk_word(OP_CLEAR, 8'h00, 3'd7));
        send_word(mk_word(OP_CLEAR, 8'hFF, 3'd7));
        send_word(mk_word(OP_CLEAR, 8'h00, 3'd0));
        send_word(mk_word(OP_RAMP,  8'hFF, 3'd0));
        send_word(mk_word(OP_RAMP,  8'hFF, 3'd0));
        send_word(mk_word(OP_RAMP,  8'h00, 3'd0));
        send_word(mk_word(OP_RAMP,  8'h05, 3'd0));
        send_word(mk_word(OP_RAMP,  8'h03, 3'd0));
        send_word(mk_word(OP_RAMP,  8'h02, 3'd0));
        send_word(mk_word(OP_WRITE, 8'hA5, 3'd0));
        send_word(mk_word(OP_SET,   8'h00, 3'd1));
        send_word(mk_word(OP_CLEAR, 8'h00, 3'd2));
        send_word(mk_word(OP_SET,   8'h00, 3'd6));
        send_word(mk_word(OP_RAMP,  8'h80, 3'd0));
        send_word(mk_word(OP_WRITE, 8'h5A, 3'd0));
        send_word(mk_word(OP_CLEAR, 8'h00, 3'd3));
        send_word(mk_word(OP_SET,   8'h00, 3'd4));
        send_word(mk_word(OP_CLEAR, 8'h00, 3'd5));

        // longest step delay: ramps would take far too long, so none here
        run_phase(DELAY_W'(16777215), 40, 1'b0, 1'b1);
        run_phase(DELAY_W'(1),        80, 1'b1, 1'b0);
        run_phase(DELAY_W'(5),        90, 1'b1, 1'b1);
        run_phase(DELAY_W'(2),        80, 1'b1, 1'b1);
        run_phase(DELAY_W'(43),       60, 1'b1, 1'b1);

        idle_until_empty(SETTLE + cur_delay);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
